/* rtl/core/ocgru_pkg.sv */
// Package for the occupancy grid ray update block.
// Holds default sizes, register indexes, register reset values, the cell word and the FSM type.
// Used by occupancy_grid_ray_update and its testbench.
`default_nettype none

package ocgru_pkg;

    localparam int GRID_WIDTH_DEF  = 256;
    localparam int GRID_HEIGHT_DEF = 256;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_FREE_INC = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HIT_INC  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CLAMP_LO = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CLAMP_HI = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OCC_LVL  = 3'd4;

    localparam logic signed [15:0] FREE_INC_RST = -16'sd102;
    localparam logic signed [15:0] HIT_INC_RST  = 16'sd218;
    localparam logic signed [15:0] CLAMP_LO_RST = -16'sd512;
    localparam logic signed [15:0] CLAMP_HI_RST = 16'sd896;
    localparam logic signed [15:0] OCC_LVL_RST  = 16'sd128;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic               seen;
        logic signed [15:0] value;
    } t_cell;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_WALK,
        S_DRAIN,
        S_QREAD,
        S_QDATA,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/ocgru_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing outside this file.
`default_nettype none

module ocgru_ram #(
    parameter  int WIDTH = 17,
    parameter  int DEPTH = 65536,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/occupancy_grid_ray_update.sv */
// Top level of the occupancy grid ray update block: FSM, Bresenham walker and grid RAM.
// Depends on ocgru_pkg and ocgru_ram.
//
//   Channel  Handshake                  Payload
//   input    i_in_valid / o_in_stall    i_req_type, origin, end, end_valid, query
//   output   o_out_valid / i_out_stall  o_ray_dropped .. o_cell_occupied
//   config   i_cfg_we                   i_cfg_index, i_cfg_data
//
// After reset the grid RAM is cleared one cell per cycle, all GRID_WIDTH*GRID_HEIGHT cells
// (65536 cells by default), and no beat is accepted until the pass ends.
// The walk of a ray reads one cell per cycle and writes it back in the next cycle
// through the single RAM write port.
// A read passes through S_ADDR, S_QREAD, S_QDATA and S_DONE; a dropped ray or off-grid read goes to S_DONE.
// A result waits in the output register while the next beat is accepted.
`default_nettype none

module occupancy_grid_ray_update
    import ocgru_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_req_type,
    input  wire logic signed [15:0]   i_src_x,
    input  wire logic signed [15:0]   i_src_y,
    input  wire logic signed [15:0]   i_end_x,
    input  wire logic signed [15:0]   i_end_y,
    input  wire logic                 i_end_valid,
    input  wire logic signed [15:0]   i_query_x,
    input  wire logic signed [15:0]   i_query_y,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_ray_dropped,
    output logic             [8:0]    o_cells_touched,
    output logic signed      [15:0]   o_cell_value,
    output logic                      o_cell_seen,
    output logic                      o_cell_occupied,
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int XW    = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int YW    = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int CW    = (XW > YW) ? XW : YW;
    localparam int EW    = CW + 4;
    localparam int CELL_W = $bits(t_cell);
    localparam logic [AW-1:0] ROW_STEP  = AW'(GRID_WIDTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
    localparam logic [AW-1:0] ONE_ADDR  = AW'(1);
    localparam logic [15:0]   W16       = 16'(GRID_WIDTH);
    localparam logic [15:0]   H16       = 16'(GRID_HEIGHT);

    t_state r_state, n_state;

    logic signed [15:0] r_free_inc, r_hit_inc, r_clamp_lo, r_clamp_hi, r_occ_lvl;

    logic                 r_req;
    logic [XW-1:0]        r_x0, r_x1;
    logic [YW-1:0]        r_y0, r_y1;
    logic                 r_sx, r_sy;
    logic signed [EW-1:0] r_dx, r_dy, r_err;
    logic [AW-1:0]        r_addr, r_clr_addr;
    logic [8:0]           r_cnt;

    logic            r_wr_pend, r_wr_hit;
    logic [AW-1:0]   r_wr_addr;

    logic               r_res_drop, r_res_seen, r_res_occ;
    logic [8:0]         r_res_cnt;
    logic signed [15:0] r_res_val;

    logic accept_in, out_free, origin_ok, end_ok, query_ok, at_end, step_x, step_y;
    logic [XW-1:0]        dx_abs;
    logic [YW-1:0]        dy_abs;
    logic signed [EW-1:0] twice, n_err;
    logic [AW-1:0]        start_addr, n_addr;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    t_cell           ram_wdata, ram_rdata;
    logic signed [15:0] upd_inc;
    logic signed [16:0] upd_sum, upd_lo, upd_hi;

    ocgru_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept_in  = i_in_valid && !o_in_stall;
    assign out_free   = !o_out_valid || !i_out_stall;

    assign origin_ok = !i_src_x[15] && ($unsigned(i_src_x) < W16)
                    && !i_src_y[15] && ($unsigned(i_src_y) < H16);
    assign end_ok    = !i_end_x[15] && ($unsigned(i_end_x) < W16)
                    && !i_end_y[15] && ($unsigned(i_end_y) < H16);
    assign query_ok  = !i_query_x[15] && ($unsigned(i_query_x) < W16)
                    && !i_query_y[15] && ($unsigned(i_query_y) < H16);

    assign dx_abs     = (r_x1 > r_x0) ? (r_x1 - r_x0) : (r_x0 - r_x1);
    assign dy_abs     = (r_y1 > r_y0) ? (r_y1 - r_y0) : (r_y0 - r_y1);
    assign start_addr = AW'(r_y0) * ROW_STEP + AW'(r_x0);

    assign at_end = (r_x0 == r_x1) && (r_y0 == r_y1);
    assign twice  = {r_err[EW-2:0], 1'b0};
    assign step_x = (twice >= r_dy);
    assign step_y = (twice <= r_dx);

    always_comb begin
        n_err  = r_err;
        n_addr = r_addr;
        if (step_x) begin
            n_err  = n_err + r_dy;
            n_addr = r_sx ? (n_addr + ONE_ADDR) : (n_addr - ONE_ADDR);
        end
        if (step_y) begin
            n_err  = n_err + r_dx;
            n_addr = r_sy ? (n_addr + ROW_STEP) : (n_addr - ROW_STEP);
        end
    end

    // Write-back stage: the cell read in the previous cycle is updated and clamped.
    always_comb begin
        upd_inc = r_wr_hit ? r_hit_inc : r_free_inc;
        upd_lo  = 17'(r_clamp_lo);
        upd_hi  = 17'(r_clamp_hi);
        upd_sum = 17'(ram_rdata.value) + 17'(upd_inc);
        if (upd_sum < upd_lo) begin
            upd_sum = upd_lo;
        end
        if (upd_sum > upd_hi) begin
            upd_sum = upd_hi;
        end
    end

    always_comb begin
        ram_we          = 1'b0;
        ram_waddr       = r_wr_addr;
        ram_wdata.seen  = 1'b1;
        ram_wdata.value = upd_sum[15:0];
        if (r_state == S_CLEAR) begin
            ram_we          = 1'b1;
            ram_waddr       = r_clr_addr;
            ram_wdata.seen  = 1'b0;
            ram_wdata.value = '0;
        end else if (r_wr_pend) begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept_in) begin
                    if (i_req_type == REQ_INSERT) begin
                        n_state = (i_end_valid && origin_ok && end_ok) ? S_ADDR : S_DONE;
                    end else begin
                        n_state = query_ok ? S_ADDR : S_DONE;
                    end
                end
            end
            S_ADDR:  n_state = (r_req == REQ_INSERT) ? S_WALK : S_QREAD;
            S_WALK: begin
                if (at_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_QREAD: n_state = S_QDATA;
            S_QDATA: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_inc <= FREE_INC_RST;
            r_hit_inc  <= HIT_INC_RST;
            r_clamp_lo <= CLAMP_LO_RST;
            r_clamp_hi <= CLAMP_HI_RST;
            r_occ_lvl  <= OCC_LVL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FREE_INC: r_free_inc <= i_cfg_data;
                REG_HIT_INC:  r_hit_inc  <= i_cfg_data;
                REG_CLAMP_LO: r_clamp_lo <= i_cfg_data;
                REG_CLAMP_HI: r_clamp_hi <= i_cfg_data;
                REG_OCC_LVL:  r_occ_lvl  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_wr_pend   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ONE_ADDR;
            end
            r_wr_pend <= (r_state == S_WALK);
            if (r_state == S_DONE && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_req      <= i_req_type;
            r_res_drop <= (i_req_type == REQ_INSERT) && !(i_end_valid && origin_ok && end_ok);
            r_res_cnt  <= '0;
            r_res_val  <= '0;
            r_res_seen <= 1'b0;
            r_res_occ  <= 1'b0;
            r_cnt      <= '0;
            if (i_req_type == REQ_INSERT) begin
                r_x0 <= i_src_x[XW-1:0];
                r_y0 <= i_src_y[YW-1:0];
            end else begin
                r_x0 <= i_query_x[XW-1:0];
                r_y0 <= i_query_y[YW-1:0];
            end
            r_x1 <= i_end_x[XW-1:0];
            r_y1 <= i_end_y[YW-1:0];
        end
        if (r_state == S_ADDR) begin
            r_addr <= start_addr;
            r_sx   <= (r_x0 < r_x1);
            r_sy   <= (r_y0 < r_y1);
            r_dx   <= $signed({{(EW - XW){1'b0}}, dx_abs});
            r_dy   <= -$signed({{(EW - YW){1'b0}}, dy_abs});
            r_err  <= $signed({{(EW - XW){1'b0}}, dx_abs})
                    - $signed({{(EW - YW){1'b0}}, dy_abs});
        end
        if (r_state == S_WALK) begin
            r_wr_addr <= r_addr;
            r_wr_hit  <= at_end;
            if (r_cnt != 9'd511) begin
                r_cnt <= r_cnt + 9'd1;
            end
            if (!at_end) begin
                r_err  <= n_err;
                r_addr <= n_addr;
                if (step_x) begin
                    r_x0 <= r_sx ? (r_x0 + XW'(1)) : (r_x0 - XW'(1));
                end
                if (step_y) begin
                    r_y0 <= r_sy ? (r_y0 + YW'(1)) : (r_y0 - YW'(1));
                end
            end
        end
        if (r_state == S_DRAIN) begin
            r_res_cnt <= r_cnt;
        end
        if (r_state == S_QDATA) begin
            r_res_val  <= ram_rdata.value;
            r_res_seen <= ram_rdata.seen;
            r_res_occ  <= ram_rdata.seen && (ram_rdata.value >= r_occ_lvl);
        end
        if (r_state == S_DONE && out_free) begin
            o_ray_dropped   <= r_res_drop;
            o_cells_touched <= r_res_cnt;
            o_cell_value    <= r_res_val;
            o_cell_seen     <= r_res_seen;
            o_cell_occupied <= r_res_occ;
        end
    end

endmodule

`default_nettype wire

/* verif/occupancy_grid_ray_update_test.sv */
// Self-checking testbench for occupancy_grid_ray_update: rays and cell reads are sent,
// a grid model in this file predicts every reply, and each reply is checked field by field.
// Depends on ocgru_pkg and the occupancy_grid_ray_update RTL only.
module occupancy_grid_ray_update_test;
    import ocgru_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_CELLS  = GRID_WIDTH_DEF * GRID_HEIGHT_DEF;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic        req_type;
        logic [15:0] src_x;
        logic [15:0] src_y;
        logic [15:0] end_x;
        logic [15:0] end_y;
        logic        end_valid;
        logic [15:0] query_x;
        logic [15:0] query_y;
    } t_grid_request;

    typedef struct packed {
        logic        ray_dropped;
        logic [8:0]  cells_touched;
        logic [15:0] cell_value;
        logic        cell_seen;
        logic        cell_occupied;
    } t_grid_reply;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_req_type = REQ_INSERT;
    logic signed [15:0]   i_src_x = '0;
    logic signed [15:0]   i_src_y = '0;
    logic signed [15:0]   i_end_x = '0;
    logic signed [15:0]   i_end_y = '0;
    logic                 i_end_valid = 1'b0;
    logic signed [15:0]   i_query_x = '0;
    logic signed [15:0]   i_query_y = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_ray_dropped;
    logic [8:0]           o_cells_touched;
    logic signed [15:0]   o_cell_value;
    logic                 o_cell_seen;
    logic                 o_cell_occupied;
    logic                 i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_index = REG_FREE_INC;
    logic [15:0]          i_cfg_data = '0;

    logic signed [15:0] grid_log_odds [0:GRID_CELLS-1];
    bit                 grid_observed [0:GRID_CELLS-1];
    logic signed [15:0] free_increment;
    logic signed [15:0] hit_increment;
    logic signed [15:0] clamp_low;
    logic signed [15:0] clamp_high;
    logic signed [15:0] occupied_level;

    t_grid_reply replies_due [$];
    int unsigned recent_end_cells [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;

    occupancy_grid_ray_update dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_src_x         (i_src_x),
        .i_src_y         (i_src_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_end_valid     (i_end_valid),
        .i_query_x       (i_query_x),
        .i_query_y       (i_query_y),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ray_dropped   (o_ray_dropped),
        .o_cells_touched (o_cells_touched),
        .o_cell_value    (o_cell_value),
        .o_cell_seen     (o_cell_seen),
        .o_cell_occupied (o_cell_occupied),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    function automatic bit on_grid(input int x, input int y);
        return x >= 0 && x < GRID_WIDTH_DEF && y >= 0 && y < GRID_HEIGHT_DEF;
    endfunction

    function automatic void clear_grid_model();
        for (int i = 0; i < GRID_CELLS; i++) begin
            grid_log_odds[i] = '0;
            grid_observed[i] = 1'b0;
        end
        free_increment = FREE_INC_RST;
        hit_increment  = HIT_INC_RST;
        clamp_low      = CLAMP_LO_RST;
        clamp_high     = CLAMP_HI_RST;
        occupied_level = OCC_LVL_RST;
    endfunction

    function automatic int accumulate_cell(input int x, input int y, input int inc);
        int sum;
        int idx;
        if (!on_grid(x, y)) return 0;
        idx = y * GRID_WIDTH_DEF + x;
        sum = grid_log_odds[idx] + inc;
        if (sum < clamp_low) sum = clamp_low;
        if (sum > clamp_high) sum = clamp_high;
        grid_log_odds[idx] = 16'(sum);
        grid_observed[idx] = 1'b1;
        return 1;
    endfunction

    // Updates the grid model with one accepted beat and returns the reply it must produce.
    function automatic t_grid_reply apply_ray_or_read(input t_grid_request r);
        t_grid_reply res;
        int x0, y0, x1, y1, dx, dy, sx, sy, err, twice, touched, idx;
        res = '0;
        if (r.req_type == REQ_INSERT) begin
            x0 = $signed(r.src_x);
            y0 = $signed(r.src_y);
            x1 = $signed(r.end_x);
            y1 = $signed(r.end_y);
            if (!r.end_valid || !on_grid(x0, y0) || !on_grid(x1, y1)) begin
                res.ray_dropped = 1'b1;
                return res;
            end
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y0 - y1 : y1 - y0;
            sx = (x0 < x1) ? 1 : -1;
            sy = (y0 < y1) ? 1 : -1;
            err = dx + dy;
            touched = 0;
            while (x0 != x1 || y0 != y1) begin
                twice = 2 * err;
                touched += accumulate_cell(x0, y0, free_increment);
                if (twice >= dy) begin
                    err += dy;
                    x0 += sx;
                end
                if (twice <= dx) begin
                    err += dx;
                    y0 += sy;
                end
            end
            touched += accumulate_cell(x1, y1, hit_increment);
            res.cells_touched = (touched > 511) ? 9'd511 : 9'(touched);
        end else begin
            x0 = $signed(r.query_x);
            y0 = $signed(r.query_y);
            if (!on_grid(x0, y0)) return res;
            idx = y0 * GRID_WIDTH_DEF + x0;
            res.cell_value    = grid_log_odds[idx];
            res.cell_seen     = grid_observed[idx];
            res.cell_occupied = grid_observed[idx] && (grid_log_odds[idx] >= occupied_level);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : check_replies
        t_grid_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                $error("Result beat arrived with no request outstanding.");
                error_count++;
            end else begin
                want = replies_due.pop_front();
                if (o_ray_dropped !== want.ray_dropped) begin
                    $error("ray_dropped: expected %0b, got %0b", want.ray_dropped, o_ray_dropped);
                    error_count++;
                end
                if (o_cells_touched !== want.cells_touched) begin
                    $error("cells_touched: expected %0d, got %0d",
                           want.cells_touched, o_cells_touched);
                    error_count++;
                end
                if (o_cell_value !== want.cell_value) begin
                    $error("cell_value: expected %0d, got %0d",
                           $signed(want.cell_value), o_cell_value);
                    error_count++;
                end
                if (o_cell_seen !== want.cell_seen) begin
                    $error("cell_seen: expected %0b, got %0b", want.cell_seen, o_cell_seen);
                    error_count++;
                end
                if (o_cell_occupied !== want.cell_occupied) begin
                    $error("cell_occupied: expected %0b, got %0b",
                           want.cell_occupied, o_cell_occupied);
                    error_count++;
                end
            end
        end
    end

    task automatic send_beat(input t_grid_request r);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_req_type  <= r.req_type;
        i_src_x     <= r.src_x;
        i_src_y     <= r.src_y;
        i_end_x     <= r.end_x;
        i_end_y     <= r.end_y;
        i_end_valid <= r.end_valid;
        i_query_x   <= r.query_x;
        i_query_y   <= r.query_y;
        i_in_valid  <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        replies_due.insert(replies_due.size(), apply_ray_or_read(r));
    endtask

    task automatic wait_replies_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] index, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
    endtask

    task automatic load_registers(input logic signed [15:0] free_inc,
                                  input logic signed [15:0] hit_inc,
                                  input logic signed [15:0] lo, input logic signed [15:0] hi,
                                  input logic signed [15:0] occ);
        write_register(REG_FREE_INC, free_inc);
        write_register(REG_HIT_INC, hit_inc);
        write_register(REG_CLAMP_LO, lo);
        write_register(REG_CLAMP_HI, hi);
        write_register(REG_OCC_LVL, occ);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        free_increment = free_inc;
        hit_increment  = hit_inc;
        clamp_low      = lo;
        clamp_high     = hi;
        occupied_level = occ;
    endtask

    task automatic load_random_registers(input bit full_range);
        if (full_range) begin
            load_registers(16'($urandom()), 16'($urandom()), 16'($urandom()),
                           16'($urandom()), 16'($urandom()));
        end else begin
            load_registers(16'(int'($urandom_range(0, 350)) - 300),
                           16'(int'($urandom_range(0, 450)) - 50),
                           16'(-int'($urandom_range(0, 2000))),
                           16'($urandom_range(0, 2000)),
                           16'(int'($urandom_range(0, 800)) - 200));
        end
    endtask

    function automatic t_grid_request make_insert(input int ox, input int oy, input int ex,
                                                  input int ey, input bit valid);
        t_grid_request r;
        r = '0;
        r.req_type  = REQ_INSERT;
        r.src_x     = 16'(ox);
        r.src_y     = 16'(oy);
        r.end_x     = 16'(ex);
        r.end_y     = 16'(ey);
        r.end_valid = valid;
        return r;
    endfunction

    function automatic t_grid_request make_read(input int qx, input int qy);
        t_grid_request r;
        r = '0;
        r.req_type = REQ_READ;
        r.query_x  = 16'(qx);
        r.query_y  = 16'(qy);
        return r;
    endfunction

    // Half of the picks fall in a small corner of the grid so that cells build up; the rest cover
    // the whole grid, the cells just outside it and arbitrary 16-bit values.
    function automatic logic [15:0] pick_coord();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 16'($urandom_range(0, 31));
        if (roll < 85) return 16'($urandom_range(0, GRID_WIDTH_DEF - 1));
        if (roll < 91) return 16'(int'($urandom_range(0, 1)) * (GRID_WIDTH_DEF + 1) - 1);
        return 16'($urandom());
    endfunction

    function automatic t_grid_request random_request();
        t_grid_request r;
        int unsigned picked;
        r.req_type  = ($urandom_range(0, 99) < 55) ? REQ_INSERT : REQ_READ;
        r.src_x     = pick_coord();
        r.src_y     = pick_coord();
        r.end_x     = pick_coord();
        r.end_y     = pick_coord();
        r.end_valid = ($urandom_range(0, 99) < 92);
        r.query_x   = 16'($urandom());
        r.query_y   = 16'($urandom());
        if (r.req_type == REQ_READ) begin
            if (recent_end_cells.size() != 0 && $urandom_range(0, 1)) begin
                picked = recent_end_cells[$urandom_range(0, recent_end_cells.size() - 1)];
                r.query_x = picked[31:16];
                r.query_y = picked[15:0];
            end else if ($urandom_range(0, 9) != 0) begin
                r.query_x = pick_coord();
                r.query_y = pick_coord();
            end
        end else if (r.end_valid && on_grid($signed(r.end_x), $signed(r.end_y))) begin
            picked = {r.end_x, r.end_y};
            recent_end_cells.insert(recent_end_cells.size(), picked);
            if (recent_end_cells.size() > 64) void'(recent_end_cells.pop_front());
        end
        return r;
    endfunction

    task automatic run_random_items(input int count);
        repeat (count) send_beat(random_request());
        wait_replies_drained();
    endtask

    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_default_registers();
        send_beat(make_read(0, 0));
        send_beat(make_read(-32768, 32767));
        send_beat(make_read(32767, -32768));
        send_beat(make_insert(5, 5, 5, 5, 1'b1));
        send_beat(make_insert(0, 0, 255, 255, 1'b1));
        send_beat(make_insert(-1, 0, 3, 3, 1'b1));
        send_beat(make_insert(3, 3, 256, 10, 1'b1));
        send_beat(make_insert(3, 3, 7, 9, 1'b0));
        send_beat(make_insert(32767, -32768, -32768, 32767, 1'b1));
        send_beat(make_read(5, 5));
        send_beat(make_read(255, 255));
        send_beat(make_insert(255, 0, 0, 17, 1'b1));
        wait_replies_drained();
    endtask

    task automatic test_register_extremes();
        load_registers(16'sh8000, 16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000);
        send_beat(make_insert(10, 10, 20, 12, 1'b1));
        send_beat(make_insert(20, 12, 20, 12, 1'b1));
        send_beat(make_read(10, 10));
        send_beat(make_read(20, 12));
        send_beat(make_read(100, 200));
        wait_replies_drained();
    endtask

    task automatic test_crossed_clamp();
        load_registers(16'sd5, 16'sd0, 16'sd1000, -16'sd1000, 16'sd32767);
        send_beat(make_insert(30, 30, 33, 31, 1'b1));
        send_beat(make_read(30, 30));
        send_beat(make_read(20, 12));
        send_beat(make_insert(40, 50, 40, 44, 1'b1));
        wait_replies_drained();
    endtask

    task automatic test_traffic_back_to_back();
        load_registers(FREE_INC_RST, HIT_INC_RST, CLAMP_LO_RST, CLAMP_HI_RST, OCC_LVL_RST);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        run_random_items(340);
    endtask

    task automatic test_traffic_sender_gaps();
        load_random_registers(1'b0);
        sender_idle_pct    = 53;
        receiver_stall_pct = 0;
        run_random_items(340);
    endtask

    task automatic test_traffic_receiver_stalls();
        load_random_registers(1'b0);
        sender_idle_pct    = 0;
        receiver_stall_pct = 53;
        run_random_items(340);
    endtask

    task automatic test_traffic_mixed_idling();
        load_random_registers(1'b1);
        sender_idle_pct    = 11;
        receiver_stall_pct = 11;
        run_random_items(340);
    endtask

    task automatic test_restart_after_drain();
        load_random_registers(1'b0);
        sender_idle_pct    = 11;
        receiver_stall_pct = 53;
        repeat (3) run_random_items(20);
        receiver_stall_pct = 0;
    endtask

    initial begin
        clear_grid_model();
        apply_reset();
        test_default_registers();
        test_register_extremes();
        test_crossed_clamp();
        test_traffic_back_to_back();
        test_traffic_sender_gaps();
        test_traffic_receiver_stalls();
        test_traffic_mixed_idling();
        test_restart_after_drain();
        wait_replies_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && replies_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
